// ----- hdl/rar_pkg.sv -----
package rar_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int FIELD_WIDTH   = 32;
   localparam int WIDE          = 64;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef struct packed {
      action_type                 action;
      logic signed [WIDE-1:0]     an;
      logic signed [WIDE-1:0]     ad;
      logic signed [WIDE-1:0]     bn;
      logic signed [WIDE-1:0]     bd;
      logic                       err;
   } job_type;

   function automatic logic signed [WIDE-1:0] sext_op(input logic [FIELD_WIDTH-1:0] v);
      sext_op = WIDE'(signed'(v[OPERAND_WIDTH-1:0]));
   endfunction

endpackage

// ----- hdl/rar_front.sv -----
module rar_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic [31:0]                 req_a_numerator,
   input  logic [31:0]                 req_a_denominator,
   input  logic [31:0]                 req_b_numerator,
   input  logic [31:0]                 req_b_denominator,
   output logic                        job_valid,
   input  logic                        job_ready,
   output rar_pkg::job_type            job
);
   import rar_pkg::*;

   job_type    mem_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   job_type    entry;
   logic       push, pop;

   always_comb begin
      entry.action = action_type'(req_action);
      entry.an     = sext_op(req_a_numerator);
      entry.ad     = sext_op(req_a_denominator);
      entry.bn     = sext_op(req_b_numerator);
      entry.bd     = sext_op(req_b_denominator);
      entry.err    = (entry.ad == '0) || (entry.bd == '0);
   end

   assign req_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = mem_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_valid && job_ready;
   assign wp_in     = push ? ~wp_ff : wp_ff;
   assign rp_in     = pop ? ~rp_ff : rp_ff;
   assign cnt_in    = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= entry;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- hdl/rar_back.sv -----
module rar_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  rar_pkg::job_type       job,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [63:0]            rsp_result_numerator,
   output logic [63:0]            rsp_result_denominator,
   output logic                   rsp_zero_denominator_error
);
   import rar_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_MUL1 = 10'b0000000010,
      ST_MUL2 = 10'b0000000100,
      ST_COMB = 10'b0000001000,
      ST_GCD  = 10'b0000010000,
      ST_FIN  = 10'b0000100000,
      ST_DIVN = 10'b0001000000,
      ST_DIVD = 10'b0010000000,
      ST_OUT  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type        st_ff, st_in;
   job_type          job_ff;
   logic [WIDE-1:0]  p0_ff, p1_ff;
   logic [WIDE-1:0]  n_ff, d_ff;
   logic [WIDE-1:0]  x_ff, y_ff;
   logic [6:0]       sh_ff;
   logic [WIDE-1:0]  rem_ff, quo_ff, dv_ff;
   logic [6:0]       cnt_ff;
   logic             neg_ff;
   logic [WIDE-1:0]  mx, my, diff, rtrial;
   logic [WIDE:0]    rsh;
   logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic [WIDE-1:0]  mul_p;
   logic             out_v_ff;
   logic [WIDE-1:0]  out_n_ff, out_d_ff;
   logic             out_e_ff;

   function automatic logic [WIDE-1:0] mag(input logic [WIDE-1:0] v);
      mag = v[WIDE-1] ? (WIDE'(0) - v) : v;
   endfunction

   assign job_ready = (st_ff == ST_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_result_numerator       = out_n_ff;
   assign rsp_result_denominator     = out_d_ff;
   assign rsp_zero_denominator_error = out_e_ff;

   always_comb begin
      unique case (st_ff)
         ST_MUL1: begin
            mul_a = job_ff.an[OPERAND_WIDTH-1:0];
            mul_b = (job_ff.action == ACT_MUL) ? job_ff.bn[OPERAND_WIDTH-1:0] :
                                                 job_ff.bd[OPERAND_WIDTH-1:0];
         end
         ST_MUL2: begin
            mul_a = job_ff.bn[OPERAND_WIDTH-1:0];
            mul_b = job_ff.ad[OPERAND_WIDTH-1:0];
         end
         default: begin
            mul_a = job_ff.ad[OPERAND_WIDTH-1:0];
            mul_b = (job_ff.action == ACT_DIV) ? job_ff.bn[OPERAND_WIDTH-1:0] :
                                                 job_ff.bd[OPERAND_WIDTH-1:0];
         end
      endcase
      mul_p = WIDE'(mul_a) * WIDE'(mul_b);
      mx    = x_ff;
      my    = y_ff;
      diff  = (mx > my) ? (mx - my) : (my - mx);
      rsh   = {rem_ff, quo_ff[WIDE-1]};
      rtrial = rsh[WIDE-1:0] - dv_ff;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (job_valid) st_in = ST_MUL1;
         ST_MUL1: st_in = ST_MUL2;
         ST_MUL2: st_in = ST_COMB;
         ST_COMB: st_in = ST_GCD;
         ST_GCD: begin
            if (job_ff.err || n_ff == '0 || d_ff == '0) begin
               st_in = ST_OUT;
            end else if (sh_ff != 7'd0 && x_ff == y_ff) begin
               st_in = ST_FIN;
            end
         end
         ST_FIN:  st_in = ST_DIVN;
         ST_DIVN: if (cnt_ff == 7'(WIDE)) st_in = ST_DIVD;
         ST_DIVD: if (cnt_ff == 7'(WIDE)) st_in = ST_OUT;
         ST_OUT:  if (!out_v_ff || rsp_ready) st_in = ST_IDLE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: if (job_valid) job_ff <= job;
         ST_MUL1: p0_ff <= mul_p;
         ST_MUL2: p1_ff <= mul_p;
         ST_COMB: begin
            unique case (job_ff.action)
               ACT_ADD: n_ff <= p0_ff + p1_ff;
               ACT_SUB: n_ff <= p0_ff - p1_ff;
               default: n_ff <= p0_ff;
            endcase
            d_ff <= mul_p;
            x_ff <= '0;
            y_ff <= '0;
            sh_ff <= '0;
         end
         default: ;
      endcase
      if (st_ff == ST_GCD) begin
         if (sh_ff == 7'd0) begin
            x_ff  <= mag(n_ff);
            y_ff  <= mag(d_ff);
            sh_ff <= 7'd1;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_ff  <= x_ff >> 1;
            y_ff  <= y_ff >> 1;
            sh_ff <= sh_ff + 7'd1;
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_ff <= diff;
         end else begin
            y_ff <= diff;
         end
      end
      if (st_ff == ST_FIN) begin
         dv_ff  <= x_ff << (sh_ff - 7'd1);
         rem_ff <= '0;
         quo_ff <= mag(n_ff);
         neg_ff <= n_ff[WIDE-1];
         cnt_ff <= '0;
      end
      if (st_ff == ST_DIVN || st_ff == ST_DIVD) begin
         if (cnt_ff == 7'(WIDE)) begin
            if (st_ff == ST_DIVN) begin
               n_ff   <= neg_ff ? (WIDE'(0) - quo_ff) : quo_ff;
               quo_ff <= mag(d_ff);
               neg_ff <= d_ff[WIDE-1];
            end else begin
               d_ff <= neg_ff ? (WIDE'(0) - quo_ff) : quo_ff;
            end
            rem_ff <= '0;
            cnt_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 7'd1;
            if (rsh[WIDE] || rsh[WIDE-1:0] >= dv_ff) begin
               rem_ff <= rtrial;
               quo_ff <= {quo_ff[WIDE-2:0], 1'b1};
            end else begin
               rem_ff <= rsh[WIDE-1:0];
               quo_ff <= {quo_ff[WIDE-2:0], 1'b0};
            end
         end
      end
      if (st_ff == ST_OUT && (!out_v_ff || rsp_ready)) begin
         out_n_ff <= job_ff.err ? '0 : n_ff;
         out_d_ff <= job_ff.err ? '0 : d_ff;
         out_e_ff <= job_ff.err;
      end
      if (reset) begin
         st_ff    <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_OUT && (!out_v_ff || rsp_ready)) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end
endmodule

// ----- hdl/rational_arith_reduce_unit.sv -----
// rational_arith_reduce_unit
// request channel: req_valid/req_ready with action and two fractions a, b.
// result channel: rsp_valid/rsp_ready with the reduced numerator and
// denominator and the zero denominator error flag; one result per request.
// the front end sign extends, checks denominators and queues up to two
// requests; the back end runs them one at a time.
// each request passes three multiplier steps, a binary gcd of shift or
// subtract steps, then two restoring divisions by the gcd (numerator,
// then denominator) and the output register.
// a request with a zero denominator or zero product skips the reduction.
// reset (synchronous, active high) empties the queue and the output register.
// a stalled receiver holds the result in the output register; the back end
// then waits and the queue fills, after which req_ready drops.
module rational_arith_reduce_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_a_numerator,
   input  logic [31:0] req_a_denominator,
   input  logic [31:0] req_b_numerator,
   input  logic [31:0] req_b_denominator,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_numerator,
   output logic [63:0] rsp_result_denominator,
   output logic        rsp_zero_denominator_error
);
   import rar_pkg::*;

   logic    job_valid, job_ready;
   job_type job;

   rar_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_action, .req_a_numerator,
      .req_a_denominator, .req_b_numerator, .req_b_denominator,
      .job_valid, .job_ready, .job
   );

   rar_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job, .rsp_valid, .rsp_ready,
      .rsp_result_numerator, .rsp_result_denominator, .rsp_zero_denominator_error
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_denominator_error |->
      rsp_result_numerator == '0 && rsp_result_denominator == '0)
      else $error("error result not 0/0");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_numerator))
      else $error("stalled result changed");
endmodule

// ----- test/tb_rational_arith_reduce_unit.sv -----
`timescale 1ns / 1ps

module tb_rational_arith_reduce_unit;
   import rar_pkg::*;

   typedef struct {
      logic [WIDE-1:0] num;
      logic [WIDE-1:0] den;
      logic            zerr;
   } fraction_type;

   typedef struct {
      action_type      act;
      logic [31:0]     an;
      logic [31:0]     ad;
      logic [31:0]     bn;
      logic [31:0]     bd;
      bit              typed;
      logic [WIDE-1:0] xn;
      logic [WIDE-1:0] xd;
      logic            xe;
   } stim_row_type;

   localparam int RANDOM_REQUESTS = 950;
   localparam logic [31:0] MAXP = 32'h7fffffff;
   localparam logic [31:0] MAXN = 32'h80000001;
   localparam logic [31:0] MOST_NEG = 32'h80000000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [31:0] req_a_numerator;
   logic [31:0] req_a_denominator;
   logic [31:0] req_b_numerator;
   logic [31:0] req_b_denominator;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_numerator;
   logic [63:0] rsp_result_denominator;
   logic        rsp_zero_denominator_error;

   fraction_type pending_fractions[$];
   int           mismatches;
   bit           quiet_tail;

   rational_arith_reduce_unit u_top (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [WIDE-1:0] widen(input logic [31:0] v);
      logic [WIDE-1:0] r;
      r = {{(WIDE-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]};
      return r;
   endfunction

   function automatic logic [WIDE-1:0] abs64(input logic [WIDE-1:0] v);
      return v[WIDE-1] ? -v : v;
   endfunction

   function automatic logic [WIDE-1:0] exact_div(input logic [WIDE-1:0] v,
                                                 input logic [WIDE-1:0] g);
      logic [WIDE-1:0] q;
      q = abs64(v) / g;
      return v[WIDE-1] ? -q : q;
   endfunction

   function automatic fraction_type reduce_fraction(input action_type act,
         input logic [31:0] an_f, input logic [31:0] ad_f,
         input logic [31:0] bn_f, input logic [31:0] bd_f);
      fraction_type r;
      logic [WIDE-1:0] an, ad, bn, bd, n, d, x, y, t;
      an = widen(an_f);
      ad = widen(ad_f);
      bn = widen(bn_f);
      bd = widen(bd_f);
      if (ad == 0 || bd == 0) begin
         r.num = '0;
         r.den = '0;
         r.zerr = 1'b1;
         return r;
      end
      case (act)
         ACT_ADD: begin
            n = an * bd + bn * ad;
            d = ad * bd;
         end
         ACT_SUB: begin
            n = an * bd - bn * ad;
            d = ad * bd;
         end
         ACT_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         default: begin
            n = an * bd;
            d = ad * bn;
         end
      endcase
      if (n != 0 && d != 0) begin
         x = abs64(n);
         y = abs64(d);
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         if (x > 1) begin
            n = exact_div(n, x);
            d = exact_div(d, x);
         end
      end
      r.num = n;
      r.den = d;
      r.zerr = 1'b0;
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, 20);
         1: v = -$urandom_range(0, 20);
         2: v = MAXP - $urandom_range(0, 3);
         3: v = MAXN + $urandom_range(0, 3);
         4: v = $urandom_range(1, 255) * ($urandom_range(0, 1) ? 32'd1 : -32'd1);
         5: v = $urandom_range(0, 1) ? 32'd1 << $urandom_range(0, 30) : MOST_NEG;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   task automatic send_request(input action_type act, input logic [31:0] an,
         input logic [31:0] ad, input logic [31:0] bn, input logic [31:0] bd);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_a_numerator <= an;
      req_a_denominator <= ad;
      req_b_numerator <= bn;
      req_b_denominator <= bd;
      pending_fractions.push_back(reduce_fraction(act, an, ad, bn, bd));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   always @(posedge clock) begin
      fraction_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fractions.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result %h/%h err %b", $time,
                     rsp_result_numerator, rsp_result_denominator,
                     rsp_zero_denominator_error);
         end else begin
            e = pending_fractions.pop_front();
            if (rsp_result_numerator !== e.num) begin
               mismatches++;
               $display("%0t: numerator expected %h actual %h", $time, e.num,
                        rsp_result_numerator);
            end
            if (rsp_result_denominator !== e.den) begin
               mismatches++;
               $display("%0t: denominator expected %h actual %h", $time, e.den,
                        rsp_result_denominator);
            end
            if (rsp_zero_denominator_error !== e.zerr) begin
               mismatches++;
               $display("%0t: error flag expected %b actual %b", $time, e.zerr,
                        rsp_zero_denominator_error);
            end
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      int burst;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 8);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   initial begin
      #(20_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      fraction_type e;
      action_type act;
      logic [31:0] an, ad, bn, bd;
      int k;
      int waited;

      mismatches = 0;
      quiet_tail = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_ADD;
      req_a_numerator = '0;
      req_a_denominator = '0;
      req_b_numerator = '0;
      req_b_denominator = '0;

      // typed rows: error cases and easy extremes
      rows.push_back('{ACT_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 1, 64'd0, 64'd0, 1'b1});
      rows.push_back('{ACT_DIV, 32'd5, 32'd3, 32'd1, 32'd0, 1, 64'd0, 64'd0, 1'b1});
      rows.push_back('{ACT_MUL, MAXP, 32'd0, MAXN, 32'd0, 1, 64'd0, 64'd0, 1'b1});
      rows.push_back('{ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd2, 1, 64'd1, 64'd1, 1'b0});
      rows.push_back('{ACT_SUB, 32'd3, 32'd4, 32'd3, 32'd4, 1, 64'd0, 64'd16, 1'b0});
      rows.push_back('{ACT_MUL, 32'd0, MAXP, MAXP, 32'd1, 1, 64'd0, {33'd0, MAXP[30:0]},
                       1'b0});
      rows.push_back('{ACT_DIV, 32'd7, 32'd1, 32'd0, 32'd5, 1, 64'd35, 64'd0, 1'b0});
      rows.push_back('{ACT_MUL, MAXP, MAXP, MAXP, MAXP, 1, 64'd1, 64'd1, 1'b0});
      // predictor-checked rows
      rows.push_back('{ACT_MUL, MAXP, 32'd1, MAXP, 32'd1, 0, 0, 0, 0});
      rows.push_back('{ACT_MUL, MAXN, 32'd1, MAXP, 32'd1, 0, 0, 0, 0});
      rows.push_back('{ACT_ADD, MAXP, MAXN, MAXN, MAXP, 0, 0, 0, 0});
      rows.push_back('{ACT_SUB, MAXN, MAXP, MAXP, MAXN, 0, 0, 0, 0});
      rows.push_back('{ACT_DIV, MAXN, MAXP, MAXP, MAXN, 0, 0, 0, 0});
      rows.push_back('{ACT_ADD, -32'd3, 32'd6, 32'd5, -32'd10, 0, 0, 0, 0});
      rows.push_back('{ACT_DIV, 32'd6, -32'd4, -32'd9, 32'd2, 0, 0, 0, 0});
      rows.push_back('{ACT_MUL, MOST_NEG, 32'd1, MOST_NEG, MOST_NEG, 0, 0, 0, 0});
      rows.push_back('{ACT_SUB, MOST_NEG, MOST_NEG, 32'd1, MOST_NEG, 0, 0, 0, 0});
      rows.push_back('{ACT_ADD, 32'h5555aaaa, 32'haaaa5555, 32'h12345678, 32'h0f0f0f0f,
                       0, 0, 0, 0});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         if (row.typed) begin
            e = reduce_fraction(row.act, row.an, row.ad, row.bn, row.bd);
            if (e.num !== row.xn || e.den !== row.xd || e.zerr !== row.xe)
               $display("%0t: table row %0d disagrees with predictor", $time, i);
         end
         send_request(row.act, row.an, row.ad, row.bn, row.bd);
         if (row.typed) pending_fractions[$] = '{row.xn, row.xd, row.xe};
      end

      for (k = 0; k < RANDOM_REQUESTS; k++) begin
         if (k > RANDOM_REQUESTS - 60) quiet_tail = 1'b1;
         act = action_type'($urandom_range(0, 3));
         an = rand_operand();
         ad = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
         bn = rand_operand();
         bd = ($urandom_range(0, 15) == 0) ? 32'd0 : rand_operand();
         send_request(act, an, ad, bn, bd);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (pending_fractions.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (500) @(posedge clock);
      if (mismatches == 0 && pending_fractions.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
